// ----- hdl/sequential_list_engine_defines.svh -----
// Assertion macros for the sequential list engine.
// No dependencies; included by the top level.
`ifndef SEQUENTIAL_LIST_ENGINE_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_DEFINES_SVH

// Check that cond holds in the same cycle as trig.
`define SLE_ASSERT_SAME(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("sle assertion failed");

// Check that cond holds in the cycle after trig.
`define SLE_ASSERT_NEXT(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("sle assertion failed");

`endif

// ----- hdl/sle_pkg.sv -----
// Shared types and constants of the sequential list engine.
// No dependencies.
package sle_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned POS_W   = 5;
   localparam int unsigned COUNT_W = 5;
   localparam int unsigned FOUND_W = 4;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned MAX_CNT = 31;
   localparam logic [4:0]  LIMIT_RESET = 5'd16;
   localparam logic [31:0] READ_FAIL   = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      OP_INSERT   = 2'd0,
      OP_DELETE   = 2'd1,
      OP_LOCATE   = 2'd2,
      OP_RETRIEVE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_NOT_EXIST = 2'd2
   } status_type;

   typedef struct packed {
      logic               do_insert;
      logic               do_delete;
      logic [POS_W-1:0]   pos;
      logic [COUNT_W-1:0] count;
      logic [VALUE_W-1:0] value;
   } cell_cmd_type;

endpackage

// ----- hdl/sle_cell.sv -----
// One list entry of the cell chain: holds a value, shifts with its neighbors.
// Depends on sle_pkg.
module sle_cell #(
   parameter int unsigned INDEX = 0
) (
   input  logic                           clock,
   input  sle_pkg::cell_cmd_type          cmd,
   input  logic [sle_pkg::VALUE_W-1:0]    left_value,
   input  logic [sle_pkg::VALUE_W-1:0]    right_value,
   input  logic [sle_pkg::VALUE_W-1:0]    cmp_value,
   output logic [sle_pkg::VALUE_W-1:0]    value,
   output logic                           match
);

   logic [sle_pkg::VALUE_W-1:0] value_ff;
   logic [sle_pkg::VALUE_W-1:0] value_in;
   logic [31:0]                 pos_x;
   logic [31:0]                 count_x;

   assign pos_x   = 32'(cmd.pos);
   assign count_x = 32'(cmd.count);

   always_comb begin
      value_in = value_ff;
      if (cmd.do_insert) begin
         if (INDEX == pos_x) begin
            value_in = cmd.value;
         end else if (INDEX > pos_x && INDEX <= count_x) begin
            value_in = left_value;
         end
      end else if (cmd.do_delete) begin
         if (INDEX >= pos_x && INDEX + 1 < count_x) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign match = (value_ff == cmp_value) && (INDEX < count_x);

endmodule

// ----- hdl/sequential_list_engine.sv -----
// Results are registered; no new request is accepted while busy is high, i.e. while a request is in flight.
// Insert and delete shift the entries from the position onward at once through the cell chain at the accepting edge;
// locate and retrieve resolve in the following cycle (match priority pick and read select).
// Synchronous reset empties the list and sets capacity_limit to 16; entry data is not cleared.
// Results cannot be stalled: rsp_valid marks each result for exactly one cycle.
// Depends on sle_pkg, sle_cell and sequential_list_engine_defines.svh.
`include "sequential_list_engine_defines.svh"
module sequential_list_engine #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_operation,
   input  logic [sle_pkg::POS_W-1:0]          req_position,
   input  logic signed [sle_pkg::VALUE_W-1:0] req_item_value,
   output logic                               rsp_valid,
   output logic [sle_pkg::STAT_W-1:0]         rsp_status,
   output logic [sle_pkg::FOUND_W-1:0]        rsp_found_index,
   output logic signed [sle_pkg::VALUE_W-1:0] rsp_read_value,
   output logic [sle_pkg::COUNT_W-1:0]        rsp_entry_count,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sle_pkg::COUNT_W-1:0]        csr_capacity_limit
);

   localparam int unsigned CAP_SAT = (CAPACITY > sle_pkg::MAX_CNT) ? sle_pkg::MAX_CNT : CAPACITY;
   localparam int unsigned SRCH    = CAP_SAT;
   localparam logic [sle_pkg::COUNT_W-1:0] CAP_LIM = sle_pkg::COUNT_W'(CAP_SAT);

   logic                           phase_ff;
   logic [sle_pkg::COUNT_W-1:0]    limit_ff;
   logic [sle_pkg::COUNT_W-1:0]    count_ff;
   logic [sle_pkg::COUNT_W-1:0]    count_in;
   sle_pkg::op_type                op_ff;
   logic [sle_pkg::POS_W-1:0]      pos_ff;
   logic [sle_pkg::VALUE_W-1:0]    val_ff;
   sle_pkg::status_type            mod_status_ff;
   sle_pkg::status_type            mod_status;

   logic                           rsp_valid_ff;
   sle_pkg::status_type            rsp_status_ff;
   logic [sle_pkg::FOUND_W-1:0]    rsp_found_ff;
   logic [sle_pkg::VALUE_W-1:0]    rsp_read_ff;
   logic [sle_pkg::COUNT_W-1:0]    rsp_count_ff;

   sle_pkg::status_type            fin_status;
   logic [sle_pkg::FOUND_W-1:0]    fin_found;
   logic [sle_pkg::VALUE_W-1:0]    fin_read;

   logic                           accept;
   sle_pkg::op_type                req_op;
   logic [sle_pkg::COUNT_W-1:0]    eff_limit;
   logic [sle_pkg::POS_W-1:0]      pos_eff;
   sle_pkg::cell_cmd_type          cmd;

   logic [sle_pkg::VALUE_W-1:0]    cell_value [CAPACITY];
   logic [CAPACITY-1:0]            cell_match;

   logic                           hit;
   logic [sle_pkg::FOUND_W-1:0]    hit_idx;
   logic [sle_pkg::VALUE_W-1:0]    sel_value;

   assign busy      = phase_ff;
   assign csr_ready = 1'b1;
   assign accept    = start && !phase_ff;
   assign req_op    = sle_pkg::op_type'(req_operation);
   assign eff_limit = (limit_ff > CAP_LIM) ? CAP_LIM : limit_ff;
   assign pos_eff   = (count_ff == '0) ? '0 : req_position;

   always_comb begin
      mod_status = sle_pkg::ST_OK;
      unique case (req_op)
         sle_pkg::OP_INSERT: begin
            if (count_ff >= eff_limit) begin
               mod_status = sle_pkg::ST_OVERFLOW;
            end else if (count_ff != '0 && req_position > count_ff) begin
               mod_status = sle_pkg::ST_NOT_EXIST;
            end
         end
         sle_pkg::OP_DELETE: begin
            if (req_position >= count_ff) begin
               mod_status = sle_pkg::ST_NOT_EXIST;
            end
         end
         default: begin
            mod_status = sle_pkg::ST_OK;
         end
      endcase
   end

   always_comb begin
      cmd.do_insert = accept && req_op == sle_pkg::OP_INSERT && mod_status == sle_pkg::ST_OK;
      cmd.do_delete = accept && req_op == sle_pkg::OP_DELETE && mod_status == sle_pkg::ST_OK;
      cmd.pos       = pos_eff;
      cmd.count     = count_ff;
      cmd.value     = req_item_value;
      count_in      = count_ff;
      if (cmd.do_insert) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.do_delete) begin
         count_in = count_ff - 1'b1;
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [sle_pkg::VALUE_W-1:0] left_v;
      logic [sle_pkg::VALUE_W-1:0] right_v;
      if (g == 0) begin : g_first
         assign left_v = req_item_value;
      end else begin : g_left
         assign left_v = cell_value[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_v = req_item_value;
      end else begin : g_right
         assign right_v = cell_value[g+1];
      end
      sle_cell #(.INDEX(g)) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .left_value  (left_v),
         .right_value (right_v),
         .cmp_value   (val_ff),
         .value       (cell_value[g]),
         .match       (cell_match[g])
      );
   end

   always_comb begin
      hit       = 1'b0;
      hit_idx   = '0;
      sel_value = '0;
      for (int i = SRCH - 1; i >= 0; i--) begin
         if (cell_match[i]) begin
            hit     = 1'b1;
            hit_idx = sle_pkg::FOUND_W'(i);
         end
         if (32'(pos_ff) == 32'(i)) begin
            sel_value = cell_value[i];
         end
      end
   end

   always_comb begin
      fin_status = mod_status_ff;
      fin_found  = '0;
      fin_read   = '0;
      case (op_ff)
         sle_pkg::OP_LOCATE: begin
            fin_status = hit ? sle_pkg::ST_OK : sle_pkg::ST_NOT_EXIST;
            fin_found  = hit ? hit_idx : '0;
         end
         sle_pkg::OP_RETRIEVE: begin
            if (pos_ff < count_ff) begin
               fin_status = sle_pkg::ST_OK;
               fin_read   = sel_value;
            end else begin
               fin_status = sle_pkg::ST_NOT_EXIST;
               fin_read   = sle_pkg::READ_FAIL;
            end
         end
         default: begin
            fin_status = mod_status_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 1'b0;
         limit_ff     <= sle_pkg::LIMIT_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= accept;
         count_ff     <= count_in;
         rsp_valid_ff <= phase_ff;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_capacity_limit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff         <= req_op;
         pos_ff        <= req_position;
         val_ff        <= req_item_value;
         mod_status_ff <= mod_status;
      end
      if (phase_ff) begin
         rsp_status_ff <= fin_status;
         rsp_found_ff  <= fin_found;
         rsp_read_ff   <= fin_read;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_read_value  = rsp_read_ff;
   assign rsp_entry_count = rsp_count_ff;

   `SLE_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy)
   `SLE_ASSERT_NEXT(a_busy_result, clock, reset, busy, rsp_valid)
   `SLE_ASSERT_SAME(a_result_idle, clock, reset, rsp_valid, !busy)
   `SLE_ASSERT_SAME(a_count_cap, clock, reset, 1'b1, count_ff <= CAP_LIM)

endmodule
